>>> design/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the sparse transpose block
// Sizes of the stores, payload widths, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int MAX_COLS    = 64;

	localparam int ROW_W = 12;
	localparam int COL_W = 7;
	localparam int VAL_W = 32;

	localparam int EIDX_W = $clog2(MAX_ENTRIES);
	localparam int CIDX_W = $clog2(MAX_COLS);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] val;
	} trip_t;

	typedef struct packed {
		logic idle;
		logic accept;
		logic inc;
		logic pf_init;
		logic pf_run;
		logic pl_rd;
		logic pl_st;
		logic pl_wr;
		logic em_rd;
		logic em_ld;
		logic em_empty;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic last_now;
		logic last_held;
		logic cnt_zero;
		logic pf_done;
		logic p_last;
		logic out_free;
	} sts_t;

endpackage

>>> design/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl: sequencer of the sparse transpose block
// Steps through load, prefix sum, placement and emission and issues one
// command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module spt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  spt_pkg::sts_t sts,
	output spt_pkg::cmd_t cmd
);
	import spt_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_INC     = 10'b00_0000_0010,
		S_PF_INIT = 10'b00_0000_0100,
		S_PREFIX  = 10'b00_0000_1000,
		S_PL_RD   = 10'b00_0001_0000,
		S_PL_ST   = 10'b00_0010_0000,
		S_PL_WR   = 10'b00_0100_0000,
		S_EM_RD   = 10'b00_1000_0000,
		S_EM_LD   = 10'b01_0000_0000,
		S_EMPTY   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.keep) begin
						state_d = S_INC;
					end else if (sts.last_now) begin
						state_d = sts.cnt_zero ? S_EMPTY : S_PF_INIT;
					end
				end
			end
			S_INC:     state_d = sts.last_held ? S_PF_INIT : S_IDLE;
			S_PF_INIT: state_d = S_PREFIX;
			S_PREFIX: begin
				if (sts.pf_done) begin
					state_d = S_PL_RD;
				end
			end
			S_PL_RD:   state_d = S_PL_ST;
			S_PL_ST:   state_d = S_PL_WR;
			S_PL_WR:   state_d = sts.p_last ? S_EM_RD : S_PL_ST;
			S_EM_RD:   state_d = S_EM_LD;
			S_EM_LD: begin
				if (sts.out_free) begin
					state_d = sts.p_last ? S_IDLE : S_EM_RD;
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.idle     = (state_q == S_IDLE);
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.inc      = (state_q == S_INC);
		cmd.pf_init  = (state_q == S_PF_INIT);
		cmd.pf_run   = (state_q == S_PREFIX);
		cmd.pl_rd    = (state_q == S_PL_RD);
		cmd.pl_st    = (state_q == S_PL_ST);
		cmd.pl_wr    = (state_q == S_PL_WR);
		cmd.em_rd    = (state_q == S_EM_RD);
		cmd.em_ld    = (state_q == S_EM_LD) && sts.out_free;
		cmd.em_empty = (state_q == S_EMPTY) && sts.out_free;
	end

endmodule

>>> design/spt_dp.sv
// ----------------------------------------------------------------------------
// spt_dp: datapath of the sparse transpose block
// Configuration registers, the four stores, counters and the output register.
// ----------------------------------------------------------------------------
module spt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spt_pkg::cmd_t                 cmd,
	output spt_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spt_pkg::CFG_W-1:0]     cfg_data,
	input  logic [spt_pkg::ROW_W-1:0]     src_row,
	input  logic [spt_pkg::COL_W-1:0]     src_col,
	input  logic signed [spt_pkg::VAL_W-1:0] entry_value,
	input  logic                          last_entry,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [spt_pkg::COL_W-1:0]     out_row,
	output logic [spt_pkg::ROW_W-1:0]     out_col,
	output logic signed [spt_pkg::VAL_W-1:0] out_value,
	output logic                          out_last,
	output logic                          entry_valid,
	output logic                          dropped
);
	import spt_pkg::*;

	// configuration
	logic [ROW_W-1:0] num_rows_q;
	logic [COL_W-1:0] num_cols_q;
	logic [COL_W-1:0] cols;

	// load state
	logic [CIDX_W-1:0] cidx_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic [MAX_COLS-1:0] cv_q;

	// stores
	trip_t            emem [MAX_ENTRIES];
	trip_t            pmem [MAX_ENTRIES];
	logic [CNT_W-1:0] cmem [MAX_COLS];
	logic [CNT_W-1:0] smem [MAX_COLS];
	trip_t            emem_rd_q;
	trip_t            pmem_rd_q;
	logic [CNT_W-1:0] cmem_rd_q;
	logic [CNT_W-1:0] smem_rd_q;

	// prefix walk
	logic [COL_W-1:0]  pc_q;
	logic              pv_s1;
	logic [CIDX_W-1:0] pidx_s1;
	logic [CNT_W-1:0]  run_q;
	logic              pf_issue;
	logic [CNT_W-1:0]  pf_cnt;

	// entry walk
	logic [CNT_W-1:0]  p_q;
	logic              p_last;
	logic [EIDX_W-1:0] emem_raddr;
	logic [CIDX_W-1:0] src_cidx;
	logic [CIDX_W-1:0] pl_cidx;

	logic keep;
	logic clr;
	logic ov_q;
	logic out_free;

	assign cols = (num_cols_q > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : num_cols_q;

	assign keep = (src_row != '0) && (src_row <= num_rows_q) &&
	              (src_col != '0) && (src_col <= cols) &&
	              (cnt_q < CNT_W'(MAX_ENTRIES));

	assign src_cidx   = CIDX_W'(src_col - COL_W'(1));
	assign pl_cidx    = CIDX_W'(emem_rd_q.col - COL_W'(1));
	assign p_last     = (p_q == cnt_q - CNT_W'(1));
	assign pf_issue   = cmd.pf_run && (pc_q < cols);
	assign pf_cnt     = cv_q[pidx_s1] ? cmem_rd_q : '0;
	assign emem_raddr = cmd.pl_wr ? EIDX_W'(p_q + CNT_W'(1)) : EIDX_W'(p_q);
	assign out_free   = !ov_q || !out_stall;
	assign clr        = (cmd.em_ld && p_last) || cmd.em_empty;

	always_comb begin
		sts           = '0;
		sts.keep      = keep;
		sts.last_now  = last_entry;
		sts.last_held = last_q;
		sts.cnt_zero  = (cnt_q == '0);
		sts.pf_done   = pv_s1 && (COL_W'(pidx_s1) == cols - COL_W'(1));
		sts.p_last    = p_last;
		sts.out_free  = out_free;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROW_W'(1);
			num_cols_q <= COL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data[ROW_W-1:0];
				REG_NUM_COLS: num_cols_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// load control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			cv_q   <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= last_entry;
				if (!keep) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.inc) begin
				cnt_q        <= cnt_q + CNT_W'(1);
				cv_q[cidx_q] <= 1'b1;
			end
			if (clr) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
				cv_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cidx_q <= src_cidx;
		end
	end

	// entry store: written on load, read during placement
	always_ff @(posedge clk) begin
		if (cmd.accept && keep) begin
			emem[EIDX_W'(cnt_q)] <= '{row: src_row, col: src_col,
			                          val: $unsigned(entry_value)};
		end
		if (cmd.pl_rd || cmd.pl_wr) begin
			emem_rd_q <= emem[emem_raddr];
		end
	end

	// column counts: read on load and during the prefix walk
	always_ff @(posedge clk) begin
		if (cmd.inc) begin
			cmem[cidx_q] <= (cv_q[cidx_q] ? cmem_rd_q : '0) + CNT_W'(1);
		end
		if (cmd.accept) begin
			cmem_rd_q <= cmem[src_cidx];
		end else if (pf_issue) begin
			cmem_rd_q <= cmem[pc_q[CIDX_W-1:0]];
		end
	end

	// prefix walk: issue a count read, then write the start in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			pv_s1 <= 1'b0;
		end else if (cmd.pf_init) begin
			pc_q  <= '0;
			pv_s1 <= 1'b0;
		end else if (cmd.pf_run) begin
			pv_s1 <= pf_issue;
			if (pf_issue) begin
				pc_q <= pc_q + COL_W'(1);
			end
		end else begin
			pv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pf_init) begin
			run_q <= '0;
		end else if (cmd.pf_run && pv_s1) begin
			run_q <= run_q + pf_cnt;
		end
		if (cmd.pf_run) begin
			pidx_s1 <= pc_q[CIDX_W-1:0];
		end
	end

	// column starts: written by the prefix walk, bumped on each placement
	always_ff @(posedge clk) begin
		if (cmd.pf_run && pv_s1) begin
			smem[pidx_s1] <= run_q;
		end else if (cmd.pl_wr) begin
			smem[pl_cidx] <= smem_rd_q + CNT_W'(1);
		end
		if (cmd.pl_st) begin
			smem_rd_q <= smem[pl_cidx];
		end
	end

	// placed store: put the triple into the slot of its column; row and
	// column swap on the way out
	always_ff @(posedge clk) begin
		if (cmd.pl_wr) begin
			pmem[smem_rd_q[EIDX_W-1:0]] <= emem_rd_q;
		end
		if (cmd.em_rd) begin
			pmem_rd_q <= pmem[EIDX_W'(p_q)];
		end
	end

	// entry walk pointer, shared by placement and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (cmd.pf_init) begin
			p_q <= '0;
		end else if (cmd.pl_wr || cmd.em_ld) begin
			p_q <= p_last ? '0 : p_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.em_ld || cmd.em_empty) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.em_ld) begin
			out_row     <= pmem_rd_q.col;
			out_col     <= pmem_rd_q.row;
			out_value   <= $signed(pmem_rd_q.val);
			out_last    <= p_last;
			entry_valid <= 1'b1;
			dropped     <= drop_q;
		end else if (cmd.em_empty) begin
			out_row     <= '0;
			out_col     <= '0;
			out_value   <= '0;
			out_last    <= 1'b1;
			entry_valid <= 1'b0;
			dropped     <= drop_q;
		end
	end

	assign out_valid = ov_q;

endmodule

>>> design/sparse_transpose_counting.sv
// ----------------------------------------------------------------------------
// sparse_transpose_counting: fast transpose of sparse matrix triples
// Loads (row, column, value) triples, counts them per column, then places
// them by a prefix sum of the counts and emits them transposed.
// ----------------------------------------------------------------------------
// Load: a stored triple reads the count memory on acceptance, then increments
//   the count and writes it back; a dropped triple skips the count step.
// After the last triple: a setup step, a prefix walk over the count memory,
//   placement (entry read, start read, write), then emission of each result
//   (placed store read, output load) while the output is not stalled.
// An empty load skips the walks; its single result waits for a free output.
// Reset: num_rows and num_cols go to 1, counts read as zero through per-column
//   valid bits, no clearing pass; the stores themselves are not reset.
module sparse_transpose_counting (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spt_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spt_pkg::ROW_W-1:0]     src_row,
	input  logic [spt_pkg::COL_W-1:0]     src_col,
	input  logic signed [spt_pkg::VAL_W-1:0] entry_value,
	input  logic                          last_entry,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spt_pkg::COL_W-1:0]     out_row,
	output logic [spt_pkg::ROW_W-1:0]     out_col,
	output logic signed [spt_pkg::VAL_W-1:0] out_value,
	output logic                          out_last,
	output logic                          entry_valid,
	output logic                          dropped
);
	import spt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: walks load, prefix, placement and emission.
	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores, counters and the output register. The output register parts
	// the two channels: a finished result may wait while the next load starts.
	spt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_row     (src_row),
		.src_col     (src_col),
		.entry_value (entry_value),
		.last_entry  (last_entry),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.out_last    (out_last),
		.entry_valid (entry_valid),
		.dropped     (dropped)
	);

	// Take a transfer only while the sequencer waits for triples.
	assign in_stall = !cmd.idle;

endmodule

>>> test/transpose_checker.sv
// ----------------------------------------------------------------------------
// transpose_checker: result predictor and scoreboard for the sparse transpose
// Watches register writes and both channels, rebuilds every transposed load
// from the accepted triples and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module transpose_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [spt_pkg::ROW_W-1:0]     src_row,
	input  logic [spt_pkg::COL_W-1:0]     src_col,
	input  logic [spt_pkg::VAL_W-1:0]     entry_value,
	input  logic                          last_entry,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [spt_pkg::COL_W-1:0]     out_row,
	input  logic [spt_pkg::ROW_W-1:0]     out_col,
	input  logic [spt_pkg::VAL_W-1:0]     out_value,
	input  logic                          out_last,
	input  logic                          entry_valid,
	input  logic                          dropped,
	output int                            mismatches,
	output int                            outstanding
);
	import spt_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [VAL_W-1:0] val;
		logic             last;
		logic             valid;
		logic             drop;
	} transposed_t;

	transposed_t      transposed_q[$];
	trip_t            loaded_q[$];
	logic [ROW_W-1:0] rows_reg;
	logic [COL_W-1:0] cols_reg;
	logic             drop_flag;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// Store or drop one triple; on the last one, emit the load in column order.
	task automatic load_entry(input trip_t t, input logic is_last);
		int          col_lim;
		int          n;
		transposed_t r;
		col_lim = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
		if (t.row == 0 || t.row > rows_reg || t.col == 0 || t.col > col_lim ||
				loaded_q.size() >= MAX_ENTRIES)
			drop_flag = 1'b1;
		else
			loaded_q.push_back(t);
		if (!is_last)
			return;
		if (loaded_q.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			r.drop = drop_flag;
			transposed_q.push_back(r);
		end else begin
			n = 0;
			for (int c = 1; c <= MAX_COLS; c++) begin
				foreach (loaded_q[p]) begin
					if (loaded_q[p].col == c) begin
						r.row   = loaded_q[p].col;
						r.col   = loaded_q[p].row;
						r.val   = loaded_q[p].val;
						r.last  = (n == loaded_q.size() - 1);
						r.valid = 1'b1;
						r.drop  = drop_flag;
						transposed_q.push_back(r);
						n++;
					end
				end
			end
		end
		loaded_q.delete();
		drop_flag = 1'b0;
	endtask

	always @(posedge clk) begin : watch
		trip_t       t;
		transposed_t want;
		if (!arst_n) begin
			rows_reg  = ROW_W'(1);
			cols_reg  = COL_W'(1);
			drop_flag = 1'b0;
			loaded_q.delete();
			transposed_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NUM_ROWS)
					rows_reg = cfg_data[ROW_W-1:0];
				else if (cfg_index == REG_NUM_COLS)
					cols_reg = cfg_data[COL_W-1:0];
			end
			if (in_valid && !in_stall) begin
				t = {src_row, src_col, entry_value};
				load_entry(t, last_entry);
			end
			if (out_valid && !out_stall) begin
				if (transposed_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = transposed_q.pop_front();
					check_field("out_row", 32'(out_row), 32'(want.row));
					check_field("out_col", 32'(out_col), 32'(want.col));
					check_field("out_value", out_value, want.val);
					check_field("out_last", 32'(out_last), 32'(want.last));
					check_field("entry_valid", 32'(entry_valid), 32'(want.valid));
					check_field("dropped", 32'(dropped), 32'(want.drop));
				end
			end
		end
		outstanding <= transposed_q.size();
	end

endmodule

>>> test/tb_sparse_transpose_counting.sv
// ----------------------------------------------------------------------------
// tb_sparse_transpose_counting: testbench of the sparse transpose block
// Drives directed and random matrix loads under several size settings with
// random gaps and output stalls; a checker beside the block predicts every
// transposed triple and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sparse_transpose_counting;
	import spt_pkg::*;

	// Cycles without any transfer before the run is declared hung. The
	// longest quiet stretch is a full load: setup, prefix walk over all
	// columns and placement of 64 entries.
	localparam int HANG_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [ROW_W-1:0]     src_row;
	logic [COL_W-1:0]     src_col;
	logic [VAL_W-1:0]     entry_value;
	logic                 last_entry;
	logic                 out_valid;
	logic                 out_stall;
	logic [COL_W-1:0]     out_row;
	logic [ROW_W-1:0]     out_col;
	logic [VAL_W-1:0]     out_value;
	logic                 out_last;
	logic                 entry_valid;
	logic                 dropped;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;

	// Size registers as last written; used to aim random triples.
	int rows_cur = 1;
	int cols_cur = 1;
	// When set, neither side inserts gaps or stalls.
	bit calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sparse_transpose_counting u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.src_row     (src_row),
		.src_col     (src_col),
		.entry_value (entry_value),
		.last_entry  (last_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.out_last    (out_last),
		.entry_valid (entry_valid),
		.dropped     (dropped)
	);

	transpose_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.src_row     (src_row),
		.src_col     (src_col),
		.entry_value (entry_value),
		.last_entry  (last_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.out_last    (out_last),
		.entry_valid (entry_valid),
		.dropped     (dropped),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Hang detection: count cycles in which neither channel moves a transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: before each result, hold stall at random (never when calm),
	// then release it and wait for the transfer.
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Write one size register; the write lands at the rising edge in between.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_size(input int rows, input int cols);
		write_reg(REG_NUM_ROWS, rows);
		write_reg(REG_NUM_COLS, cols);
		rows_cur = rows;
		cols_cur = cols;
	endtask

	// Present one triple after a random gap and hold it until transferred.
	task automatic push_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [VAL_W-1:0] val, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_row     <= row;
		src_col     <= col;
		entry_value <= val;
		last_entry  <= last;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Drop valid and wait until every expected result has been transferred,
	// then let the block return to loading.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	// Send one matrix of n triples, the final one marked last. With noise,
	// about one triple in eight falls outside the configured sizes.
	task automatic load_matrix(input int n, input bit noisy);
		int               col_lim;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		col_lim = (cols_cur > MAX_COLS) ? MAX_COLS : cols_cur;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0:       row = ROW_W'(rows_cur);
				1:       row = ROW_W'(1);
				default: row = ROW_W'($urandom_range(1, rows_cur));
			endcase
			col = ($urandom_range(0, 3) == 0) ? COL_W'(col_lim) :
			                                    COL_W'($urandom_range(1, col_lim));
			if (noisy && $urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: row = '0;
					1: col = '0;
					2: row = (rows_cur < 4095) ?
					         ROW_W'($urandom_range(rows_cur + 1, 4095)) : '0;
					default: col = (col_lim < 127) ?
					               COL_W'($urandom_range(col_lim + 1, 127)) : '0;
				endcase
			end
			push_entry(row, col, $urandom, k == n - 1);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_NUM_ROWS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		src_row     = '0;
		src_col     = '0;
		entry_value = '0;
		last_entry  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset sizes are one row and one column: one kept entry, then a
		// load whose only triple is dropped, giving the empty-load marker.
		push_entry(12'd1, 7'd1, 32'h0000_0001, 1'b1);
		push_entry(12'd0, 7'd1, 32'h0000_0005, 1'b1);
		settle();

		// Full-size matrix: extreme rows, columns and values, a zero column
		// and a column past the column store, ending on a mid column.
		set_size(4095, 64);
		push_entry(12'd4095, 7'd64, 32'h7FFF_FFFF, 1'b0);
		push_entry(12'd1,    7'd1,  32'h8000_0000, 1'b0);
		push_entry(12'd2,    7'd64, 32'hFFFF_FFFF, 1'b0);
		push_entry(12'd3,    7'd1,  32'h0000_0000, 1'b0);
		push_entry(12'd1,    7'd0,  32'h0000_1234, 1'b0);
		push_entry(12'd1,    7'd127, 32'hA5A5_A5A5, 1'b0);
		push_entry(12'd4095, 7'd33, 32'h5A5A_5A5A, 1'b1);
		// Last triple dropped with nothing stored, then a clean two-entry
		// column to show stable order.
		push_entry(12'd0, 7'd0, 32'h0, 1'b1);
		push_entry(12'd7, 7'd2, 32'h0000_000A, 1'b0);
		push_entry(12'd9, 7'd2, 32'h0000_000B, 1'b1);
		settle();

		// Column register above the store size: clamp to the column store.
		set_size(4095, 127);
		push_entry(12'd10, 7'd100, 32'h1111_1111, 1'b0);
		push_entry(12'd11, 7'd64,  32'h2222_2222, 1'b1);
		settle();

		// Zero rows, then zero columns: every triple is dropped.
		set_size(0, 64);
		push_entry(12'd1, 7'd1, 32'h3333_3333, 1'b1);
		settle();
		set_size(4095, 0);
		push_entry(12'd5, 7'd1, 32'h4444_4444, 1'b1);
		settle();

		// Small matrix: row just past the limit, columns reordered on output.
		set_size(3, 2);
		push_entry(12'd4, 7'd1, 32'h5555_5555, 1'b0);
		push_entry(12'd3, 7'd2, 32'h6666_6666, 1'b0);
		push_entry(12'd1, 7'd1, 32'h7777_7777, 1'b1);
		settle();

		// Random loads. Between loads, pause for all results about half the
		// time and run straight on otherwise.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       set_size(4095, 64);
				1:       set_size($urandom_range(1, 4095), $urandom_range(1, 64));
				2:       set_size(4095, 64);
				default: set_size($urandom_range(1, 60), $urandom_range(65, 127));
			endcase
			calm = (ph == 1);
			// Overfill the store once: 64 kept, the rest dropped as full.
			if (ph == 2)
				load_matrix(66, 1'b0);
			repeat ((ph == 2) ? 2 : 4) begin
				load_matrix($urandom_range(1, 6), 1'b1);
				if ($urandom_range(0, 1) == 1)
					settle();
			end
			settle();
		end
		calm = 1'b0;

		// Allow stray results to show up before the verdict.
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
